/* rtl/ttd_pkg.sv */
// shared constants, command and status codes and table port types
// for the time-triggered task dispatcher; used by ttd_table and the rtl top
`default_nettype none

package ttd_pkg;

    localparam int MAX_TASKS = 8;
    localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);

    localparam logic [3:0] TABLE_LIMIT_RST = 4'd8;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_TICK   = 2'd1;
    localparam logic [1:0] CMD_REPORT = 2'd2;

    localparam logic [2:0] ST_ADDED    = 3'd0;
    localparam logic [2:0] ST_ADD_REJ  = 3'd1;
    localparam logic [2:0] ST_DISPATCH = 3'd2;
    localparam logic [2:0] ST_DONE     = 3'd3;
    localparam logic [2:0] ST_FAULT    = 3'd4;
    localparam logic [2:0] ST_CMD_REJ  = 3'd5;

    typedef struct packed {
        logic             add_en;
        logic             cd_en;
        logic             worst_en;
        logic [IDX_W-1:0] idx;
        logic [15:0]      countdown;
        logic [15:0]      period;
        logic [31:0]      min_time;
        logic [31:0]      max_time;
        logic [31:0]      worst;
    } tbl_wr_t;

    typedef struct packed {
        logic [15:0] countdown;
        logic [15:0] period;
        logic [31:0] min_time;
        logic [31:0] max_time;
        logic [31:0] worst;
    } tbl_entry_t;

endpackage

`default_nettype wire

/* rtl/ttd_table.sv */
// task table storage: countdown, period, run-time window and worst time
// per entry; one write port, one registered read port; uses ttd_pkg
`default_nettype none

module ttd_table (
    input  wire logic                    clk,
    input  wire ttd_pkg::tbl_wr_t        wr,
    input  wire logic [ttd_pkg::IDX_W-1:0] rd_idx,
    output ttd_pkg::tbl_entry_t          rd
);
    import ttd_pkg::*;

    logic [15:0] cd_mem    [MAX_TASKS];
    logic [15:0] per_mem   [MAX_TASKS];
    logic [31:0] min_mem   [MAX_TASKS];
    logic [31:0] max_mem   [MAX_TASKS];
    logic [31:0] worst_mem [MAX_TASKS];

    always_ff @(posedge clk)
    begin
        if (wr.add_en)
        begin
            cd_mem[wr.idx]    <= wr.countdown;
            per_mem[wr.idx]   <= wr.period;
            min_mem[wr.idx]   <= wr.min_time;
            max_mem[wr.idx]   <= wr.max_time;
            worst_mem[wr.idx] <= '0;
        end
        else
        begin
            if (wr.cd_en)
            begin
                cd_mem[wr.idx] <= wr.countdown;
            end
            if (wr.worst_en)
            begin
                worst_mem[wr.idx] <= wr.worst;
            end
        end
    end

    // read data is registered: it appears in the cycle after the address
    always_ff @(posedge clk)
    begin
        rd.countdown <= cd_mem[rd_idx];
        rd.period    <= per_mem[rd_idx];
        rd.min_time  <= min_mem[rd_idx];
        rd.max_time  <= max_mem[rd_idx];
        rd.worst     <= worst_mem[rd_idx];
    end

endmodule

`default_nettype wire

/* rtl/ttd_unit.sv */
// shared subtract/compare unit: difference and borrow of two 32-bit words
// used for countdown decrement, period reload and run-time checks; no deps
`default_nettype none

module ttd_unit (
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic [31:0]      diff,
    output logic             borrow
);
    logic [32:0] wide;

    always_comb
    begin
        wide   = {1'b0, a} - {1'b0, b};
        diff   = wide[31:0];
        borrow = wide[32];
    end

endmodule

`default_nettype wire

/* rtl/time_triggered_task_dispatcher.sv */
// Time-triggered task dispatcher, top level. Depends on ttd_pkg, ttd_table, ttd_unit.
//
// Command channel (in_valid/in_ready) takes add, tick and report commands; the
// result channel (out_valid/out_ready) returns exactly one result per command.
// One command is worked on at a time; in_ready is high only while idle.
// An add or a rejected command goes from decode straight to the result stage;
// a tick walks the table from entry 0, decrementing each countdown, and stops
// at the first entry found at zero, which is reloaded from its period and
// dispatched; a report checks the window (min, then max) and the worst time
// before resuming the scan, or ends in a fault. The single shared subtractor
// handles one table entry or one compare per cycle.
// The result sits in an output register; the next command is accepted while
// it waits, and a new result waits in the sequencer until the old one is taken.
// APB port: table_limit at byte address 0, pready always high.
// Reset (rst_n low, asynchronous) empties the table, clears the fault and any
// pending dispatch, and sets table_limit to 8. No clearing pass is needed.
`default_nettype none

module time_triggered_task_dispatcher (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  cmd,
    input  wire logic [15:0] start_offset,
    input  wire logic [15:0] period,
    input  wire logic [31:0] min_time,
    input  wire logic [31:0] max_time,
    input  wire logic [31:0] measured_time,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [2:0]       task_index,
    output logic [31:0]      worst_time
);
    import ttd_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DECODE  = 3'd1;
    localparam logic [2:0] S_SCAN    = 3'd2;
    localparam logic [2:0] S_RELOAD  = 3'd3;
    localparam logic [2:0] S_CHK_MIN = 3'd4;
    localparam logic [2:0] S_CHK_MAX = 3'd5;
    localparam logic [2:0] S_WORST   = 3'd6;
    localparam logic [2:0] S_EMIT    = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [1:0]       cmd_reg;
    logic [15:0]      offset_reg;
    logic [15:0]      period_reg;
    logic [31:0]      min_reg;
    logic [31:0]      max_reg;
    logic [31:0]      time_reg;
    logic [3:0]       table_limit_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] cursor_reg, cursor_next;
    logic             awaiting_reg, awaiting_next;
    logic             fault_reg, fault_next;
    logic             outside_reg, outside_next;
    logic [IDX_W-1:0] rep_idx_reg, rep_idx_next;
    logic [2:0]       res_status_reg, res_status_next;
    logic [2:0]       res_idx_reg, res_idx_next;
    logic [31:0]      res_worst_reg, res_worst_next;
    logic             out_valid_reg, out_valid_next;
    logic [2:0]       status_reg;
    logic [2:0]       task_index_reg;
    logic [31:0]      worst_time_reg;

    logic             accept;
    logic             out_load;
    logic             cfg_write;
    logic             table_full;
    logic [IDX_W-1:0] rd_idx;
    logic [31:0]      unit_a, unit_b, unit_diff;
    logic             unit_borrow;
    logic [31:0]      new_worst;
    tbl_wr_t          wr;
    tbl_entry_t       ent;

    ttd_table u_table (
        .clk    (clk),
        .wr     (wr),
        .rd_idx (rd_idx),
        .rd     (ent)
    );

    ttd_unit u_unit (
        .a      (unit_a),
        .b      (unit_b),
        .diff   (unit_diff),
        .borrow (unit_borrow)
    );

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == 1'b0) ? {28'd0, table_limit_reg} : 32'd0;

    assign in_ready   = (state_reg == S_IDLE);
    assign accept     = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign task_index = task_index_reg;
    assign worst_time = worst_time_reg;

    assign out_load   = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);
    assign table_full = (32'(count_reg) >= 32'(table_limit_reg))
                     || (32'(count_reg) >= 32'(MAX_TASKS));
    // table read is registered, so address the entry the next state works on
    assign rd_idx     = (state_next inside {S_CHK_MIN, S_CHK_MAX, S_WORST})
                      ? rep_idx_next : cursor_next[IDX_W-1:0];
    assign new_worst  = unit_borrow ? time_reg : ent.worst;

    // operand selection for the shared subtractor
    always_comb
    begin
        unit_a = 32'd0;
        unit_b = 32'd0;
        case (state_reg)
            S_SCAN:
            begin
                unit_a = {16'd0, ent.countdown};
                unit_b = 32'd1;
            end
            S_RELOAD:
            begin
                unit_a = {16'd0, ent.period};
                unit_b = 32'd1;
            end
            S_CHK_MIN:
            begin
                unit_a = time_reg;
                unit_b = ent.min_time;
            end
            S_CHK_MAX:
            begin
                unit_a = ent.max_time;
                unit_b = time_reg;
            end
            S_WORST:
            begin
                unit_a = ent.worst;
                unit_b = time_reg;
            end
            default:
            begin
                unit_a = 32'd0;
                unit_b = 32'd0;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        cursor_next     = cursor_reg;
        awaiting_next   = awaiting_reg;
        fault_next      = fault_reg;
        outside_next    = outside_reg;
        rep_idx_next    = rep_idx_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        res_worst_next  = res_worst_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        wr              = '0;
        wr.idx          = count_reg[IDX_W-1:0];
        wr.countdown    = offset_reg;
        wr.period       = period_reg;
        wr.min_time     = min_reg;
        wr.max_time     = max_reg;
        wr.worst        = new_worst;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                res_status_next = ST_CMD_REJ;
                res_idx_next    = 3'd0;
                res_worst_next  = 32'd0;
                state_next      = S_EMIT;
                if (!fault_reg)
                begin
                    case (cmd_reg)
                        CMD_ADD:
                        begin
                            if (!awaiting_reg)
                            begin
                                if (period_reg == 16'd0 || table_full)
                                begin
                                    res_status_next = ST_ADD_REJ;
                                end
                                else
                                begin
                                    wr.add_en       = 1'b1;
                                    count_next      = count_reg + 1'b1;
                                    res_status_next = ST_ADDED;
                                    res_idx_next    = 3'(count_reg[IDX_W-1:0]);
                                end
                            end
                        end
                        CMD_TICK:
                        begin
                            if (!awaiting_reg)
                            begin
                                cursor_next = '0;
                                state_next  = S_SCAN;
                            end
                        end
                        CMD_REPORT:
                        begin
                            if (awaiting_reg && cursor_reg != '0)
                            begin
                                rep_idx_next = IDX_W'(cursor_reg - 1'b1);
                                state_next   = S_CHK_MIN;
                            end
                        end
                        default:
                        begin
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (cursor_reg >= count_reg)
                begin
                    cursor_next     = '0;
                    res_status_next = ST_DONE;
                    res_idx_next    = 3'd0;
                    state_next      = S_EMIT;
                end
                else if (unit_borrow)
                begin
                    // countdown at zero: dispatch this entry
                    state_next = S_RELOAD;
                end
                else
                begin
                    wr.cd_en     = 1'b1;
                    wr.idx       = cursor_reg[IDX_W-1:0];
                    wr.countdown = unit_diff[15:0];
                    cursor_next  = cursor_reg + 1'b1;
                end
            end
            S_RELOAD:
            begin
                wr.cd_en        = 1'b1;
                wr.idx          = cursor_reg[IDX_W-1:0];
                wr.countdown    = unit_diff[15:0];
                awaiting_next   = 1'b1;
                cursor_next     = cursor_reg + 1'b1;
                res_status_next = ST_DISPATCH;
                res_idx_next    = 3'(cursor_reg[IDX_W-1:0]);
                state_next      = S_EMIT;
            end
            S_CHK_MIN:
            begin
                outside_next = unit_borrow;
                state_next   = S_CHK_MAX;
            end
            S_CHK_MAX:
            begin
                outside_next = outside_reg || unit_borrow;
                state_next   = S_WORST;
            end
            S_WORST:
            begin
                wr.worst_en    = 1'b1;
                wr.idx         = rep_idx_reg;
                awaiting_next  = 1'b0;
                res_worst_next = new_worst;
                if (outside_reg)
                begin
                    fault_next      = 1'b1;
                    cursor_next     = '0;
                    res_status_next = ST_FAULT;
                    res_idx_next    = 3'(rep_idx_reg);
                    state_next      = S_EMIT;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            table_limit_reg <= TABLE_LIMIT_RST;
            count_reg       <= '0;
            cursor_reg      <= '0;
            awaiting_reg    <= 1'b0;
            fault_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cursor_reg    <= cursor_next;
            awaiting_reg  <= awaiting_next;
            fault_reg     <= fault_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write && paddr[2] == 1'b0)
            begin
                table_limit_reg <= pwdata[3:0];
            end
        end
    end

    // payload and result registers
    always_ff @(posedge clk)
    begin
        outside_reg    <= outside_next;
        rep_idx_reg    <= rep_idx_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        res_worst_reg  <= res_worst_next;
        if (accept)
        begin
            cmd_reg    <= cmd;
            offset_reg <= start_offset;
            period_reg <= period;
            min_reg    <= min_time;
            max_reg    <= max_time;
            time_reg   <= measured_time;
        end
        if (out_load)
        begin
            status_reg     <= res_status_reg;
            task_index_reg <= res_idx_reg;
            worst_time_reg <= res_worst_reg;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(MAX_TASKS))
        else $error("task count beyond table size");

    a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= count_reg)
        else $error("scan cursor beyond task count");

    a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        fault_reg |=> fault_reg)
        else $error("fault cleared without reset");

    a_fault_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        fault_reg |-> !awaiting_reg)
        else $error("dispatch pending after fault");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(status_reg)
        && $stable(task_index_reg) && $stable(worst_time_reg)))
        else $error("result changed while stalled");
`endif

endmodule

`default_nettype wire

/* tb/tb_time_triggered_task_dispatcher.sv */
// testbench for the time-triggered task dispatcher: directed and random commands,
// a scoreboard class predicts every result; depends on ttd_pkg and the rtl top
`default_nettype none

module tb_time_triggered_task_dispatcher;

    import ttd_pkg::*;

    localparam logic [1:0] CMD_UNUSED      = 2'd3;
    localparam logic [2:0] REG_TABLE_LIMIT = 3'd0;
    localparam int         LIMIT_CYCLES    = 400000;
    localparam int         PHASE_ITEMS     = 212;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  idx;
        logic [31:0] worst;
    } dispatch_result_t;

    class dispatch_scoreboard;
        logic [3:0]       limit_reg;
        int               tasks_held;
        int               next_entry;
        bit               report_due;
        bit               fault_seen;
        logic [15:0]      remaining[MAX_TASKS];
        logic [15:0]      period_of[MAX_TASKS];
        logic [31:0]      min_of[MAX_TASKS];
        logic [31:0]      max_of[MAX_TASKS];
        logic [31:0]      last_run[MAX_TASKS];
        logic [31:0]      worst_run[MAX_TASKS];
        dispatch_result_t expected_results[$];
        int               mismatches;

        function new();
            limit_reg  = TABLE_LIMIT_RST;
            tasks_held = 0;
            next_entry = 0;
            report_due = 1'b0;
            fault_seen = 1'b0;
            mismatches = 0;
            foreach (remaining[i])
            begin
                remaining[i] = '0;
                period_of[i] = '0;
                min_of[i]    = '0;
                max_of[i]    = '0;
                last_run[i]  = '0;
                worst_run[i] = '0;
            end
        endfunction

        function int room_limit();
            return (limit_reg > MAX_TASKS) ? MAX_TASKS : int'(limit_reg);
        endfunction

        // walk the table from next_entry until an entry is due or the round ends
        function dispatch_result_t resume_scan(logic [31:0] worst);
            dispatch_result_t r;
            r       = '0;
            r.worst = worst;
            for (int i = next_entry; i < tasks_held && i < MAX_TASKS; i++)
            begin
                if (remaining[i] != 16'd0)
                begin
                    remaining[i] = remaining[i] - 16'd1;
                end
                else
                begin
                    remaining[i] = period_of[i] - 16'd1;
                    report_due   = 1'b1;
                    next_entry   = i + 1;
                    r.status     = ST_DISPATCH;
                    r.idx        = 3'(i);
                    return r;
                end
            end
            next_entry = 0;
            r.status   = ST_DONE;
            return r;
        endfunction

        function void note_command(logic [1:0] c, logic [15:0] ofs, logic [15:0] per,
                                   logic [31:0] lo, logic [31:0] hi, logic [31:0] meas);
            dispatch_result_t r;
            int               k;
            r        = '0;
            r.status = ST_CMD_REJ;
            if (!fault_seen)
            begin
                case (c)
                    CMD_ADD:
                    begin
                        if (report_due)
                        begin
                            r.status = ST_CMD_REJ;
                        end
                        else if (per == 16'd0 || tasks_held >= room_limit())
                        begin
                            r.status = ST_ADD_REJ;
                        end
                        else
                        begin
                            k            = tasks_held;
                            remaining[k] = ofs;
                            period_of[k] = per;
                            min_of[k]    = lo;
                            max_of[k]    = hi;
                            last_run[k]  = '0;
                            worst_run[k] = '0;
                            tasks_held   = k + 1;
                            r.status     = ST_ADDED;
                            r.idx        = 3'(k);
                        end
                    end
                    CMD_TICK:
                    begin
                        if (!report_due)
                        begin
                            next_entry = 0;
                            r          = resume_scan(32'd0);
                        end
                    end
                    CMD_REPORT:
                    begin
                        if (report_due && next_entry != 0 && next_entry <= MAX_TASKS)
                        begin
                            k           = next_entry - 1;
                            report_due  = 1'b0;
                            last_run[k] = meas;
                            if (worst_run[k] < meas)
                                worst_run[k] = meas;
                            if (meas < min_of[k] || meas > max_of[k])
                            begin
                                fault_seen = 1'b1;
                                next_entry = 0;
                                r.status   = ST_FAULT;
                                r.idx      = 3'(k);
                                r.worst    = worst_run[k];
                            end
                            else
                            begin
                                r = resume_scan(worst_run[k]);
                            end
                        end
                    end
                    default:
                    begin
                        r.status = ST_CMD_REJ;
                    end
                endcase
            end
            expected_results.push_back(r);
        endfunction

        function void check_result(logic [2:0] st, logic [2:0] idx, logic [31:0] worst);
            dispatch_result_t e;
            if (expected_results.size() == 0)
            begin
                $error("result with none expected: status %0d task_index %0d worst_time %0d",
                       st, idx, worst);
                mismatches++;
                return;
            end
            e = expected_results.pop_front();
            if (st !== e.status)
            begin
                $error("status: expected %0d, actual %0d", e.status, st);
                mismatches++;
            end
            if (idx !== e.idx)
            begin
                $error("task_index: expected %0d, actual %0d", e.idx, idx);
                mismatches++;
            end
            if (worst !== e.worst)
            begin
                $error("worst_time: expected %0d, actual %0d", e.worst, worst);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  cmd;
    logic [15:0] start_offset;
    logic [15:0] period;
    logic [31:0] min_time;
    logic [31:0] max_time;
    logic [31:0] measured_time;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [2:0]  task_index;
    logic [31:0] worst_time;

    dispatch_scoreboard sb;
    int                 send_idle_pct = 0;
    int                 stall_pct     = 0;
    bit                 pressure_go   = 1'b0;
    logic               hold_off;
    int                 cycle_count;

    time_triggered_task_dispatcher u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .start_offset  (start_offset),
        .period        (period),
        .min_time      (min_time),
        .max_time      (max_time),
        .measured_time (measured_time),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .task_index    (task_index),
        .worst_time    (worst_time)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // result side: random stalls plus the long hold-off
    always @(posedge clk)
    begin
        if (out_valid === 1'b1 && out_ready === 1'b1)
            sb.check_result(status, task_index, worst_time);
        out_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end

    initial
    begin
        hold_off <= 1'b0;
        wait (pressure_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_time_triggered_task_dispatcher: errors");
        $finish;
    end

    task automatic send_command(input logic [1:0] c, input logic [15:0] ofs,
                                input logic [15:0] per, input logic [31:0] lo,
                                input logic [31:0] hi, input logic [31:0] meas);
        in_valid      <= 1'b1;
        cmd           <= c;
        start_offset  <= ofs;
        period        <= per;
        min_time      <= lo;
        max_time      <= hi;
        measured_time <= meas;
        do @(posedge clk); while (in_ready !== 1'b1);
        sb.note_command(c, ofs, per, lo, hi, meas);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic send_add(input logic [15:0] ofs, input logic [15:0] per,
                            input logic [31:0] lo, input logic [31:0] hi);
        send_command(CMD_ADD, ofs, per, lo, hi, $urandom);
    endtask

    task automatic send_tick();
        send_command(CMD_TICK, 16'($urandom), 16'($urandom), $urandom, $urandom, $urandom);
    endtask

    task automatic send_report(input logic [31:0] meas);
        send_command(CMD_REPORT, 16'($urandom), 16'($urandom), $urandom, $urandom, meas);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(posedge clk);
    endtask

    // write then read back, only while the block is idle
    task automatic write_table_limit(input logic [3:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_TABLE_LIMIT;
        pwdata  <= {28'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        sb.limit_reg = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        if (prdata !== {28'd0, value})
        begin
            $error("prdata: expected %0d, actual %0d", value, prdata);
            sb.mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic random_item();
        int          roll;
        int          k;
        logic [31:0] lo;
        logic [31:0] hi;
        roll = $urandom_range(99);
        if (sb.report_due)
        begin
            k  = sb.next_entry - 1;
            lo = sb.min_of[k];
            hi = sb.max_of[k];
            if (roll < 10)
                send_report(lo);
            else if (roll < 20)
                send_report(hi);
            else if (roll < 85)
                send_report($urandom_range(hi, lo));
            else if (roll < 92)
                send_tick();
            else if (roll < 97)
                send_add(16'($urandom), 16'($urandom), $urandom, $urandom);
            else
                send_command(CMD_UNUSED, 16'($urandom), 16'($urandom), $urandom, $urandom,
                             $urandom);
        end
        else if (roll < 60)
        begin
            send_tick();
        end
        else if (roll < 70)
        begin
            send_report($urandom);
        end
        else if (roll < 90)
        begin
            if (sb.tasks_held < sb.room_limit())
            begin
                if ($urandom_range(1) == 0)
                begin
                    lo = 32'd0;
                    hi = 32'hFFFF_FFFF;
                end
                else
                begin
                    lo = $urandom_range(1000, 0);
                    hi = $urandom_range(32'hFFFF_FFFF, 32'h8000_0000);
                end
                send_add(16'($urandom_range(5, 0)), 16'($urandom_range(8, 1)), lo, hi);
            end
            else
            begin
                // table full, so any field values are rejected
                send_add(16'($urandom), 16'($urandom), $urandom, $urandom);
            end
        end
        else if (roll < 95)
        begin
            send_add(16'($urandom), 16'd0, $urandom, $urandom);
        end
        else
        begin
            send_command(CMD_UNUSED, 16'($urandom), 16'($urandom), $urandom, $urandom,
                         $urandom);
        end
    endtask

    initial
    begin
        int          phase_idle[4];
        int          phase_stall[4];
        logic [3:0]  phase_limit[4];
        int          k;

        phase_idle  = '{0, 75, 0, 37};
        phase_stall = '{0, 0, 75, 37};
        phase_limit = '{4'd8, 4'd15, 4'd5, 4'd12};

        sb = new();
        rst_n         <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        in_valid      <= 1'b0;
        cmd           <= CMD_TICK;
        start_offset  <= '0;
        period        <= '0;
        min_time      <= '0;
        max_time      <= '0;
        measured_time <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // empty table, limit zero, stray commands
        write_table_limit(4'd0);
        send_add(16'd0, 16'd1, 32'd0, 32'hFFFF_FFFF);
        send_tick();
        send_report(32'd5);
        send_command(CMD_UNUSED, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0);
        drain();

        write_table_limit(4'd3);
        send_add(16'hFFFF, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_add(16'd0, 16'd1, 32'd0, 32'hFFFF_FFFF);
        send_add(16'd0, 16'd2, 32'd100, 32'd200);
        send_add(16'd1, 16'hFFFF, 32'd0, 32'hFFFF_FFFF);
        send_add(16'd0, 16'd1, 32'd0, 32'hFFFF_FFFF);
        send_tick();
        send_add(16'd0, 16'd1, 32'd0, 32'hFFFF_FFFF);
        send_tick();
        send_report(32'd0);
        send_report(32'd200);
        send_tick();
        send_report(32'hFFFF_FFFF);
        send_report(32'd100);
        drain();

        // limit lowered below the number of entries already held
        write_table_limit(4'd2);
        send_add(16'd0, 16'd1, 32'd0, 32'hFFFF_FFFF);
        drain();

        write_table_limit(4'd15);
        send_add(16'd3, 16'd4, 32'd0, 32'hFFFF_FFFF);

        for (int p = 0; p < 4; p++)
        begin
            drain();
            write_table_limit(phase_limit[p]);
            send_idle_pct = phase_idle[p];
            stall_pct     = phase_stall[p];
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == 0 && n == 50)
                    pressure_go = 1'b1;
                random_item();
            end
        end

        // finish with a timing fault, then everything must be refused
        for (int n = 0; n < 64 && !sb.fault_seen; n++)
        begin
            if (sb.report_due)
            begin
                k = sb.next_entry - 1;
                if (sb.min_of[k] != 32'd0)
                    send_report(sb.min_of[k] - 32'd1);
                else if (sb.max_of[k] != 32'hFFFF_FFFF)
                    send_report(sb.max_of[k] + 32'd1);
                else
                    send_report($urandom);
            end
            else
            begin
                send_tick();
            end
        end
        send_add(16'd0, 16'd1, 32'd0, 32'hFFFF_FFFF);
        send_tick();
        send_report(32'd150);
        send_command(CMD_UNUSED, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0);

        drain();
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0)
            $display("tb_time_triggered_task_dispatcher: clean");
        else
            $display("tb_time_triggered_task_dispatcher: errors");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
rtl/ttd_pkg.sv
rtl/ttd_table.sv
rtl/ttd_unit.sv
rtl/time_triggered_task_dispatcher.sv
tb/tb_time_triggered_task_dispatcher.sv
